### src/sfom_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfom_pkg - shared types and constants of the scale frame overload monitor
// Item kinds, queue entry layout, register indexes and reset values.
// ----------------------------------------------------------------------------
package sfom_pkg;

    localparam int FRAME_CHARS_DEF = 8;
    localparam int FRAME_W         = 64;
    localparam int CHAR_W          = 8;
    localparam int WEIGHT_W        = 16;
    localparam int QUEUE_DEPTH     = 2;
    localparam int CFG_IDX_W       = 4;
    localparam int CFG_DATA_W      = 16;
    localparam int CNT_W           = 4;

    typedef enum logic [1:0] {
        KIND_TOTAL = 2'd0,
        KIND_FAIL  = 2'd1,
        KIND_INCR  = 2'd2,
        KIND_ACK   = 2'd3
    } t_kind;

    // Decoded item as it travels through the queue
    typedef struct packed {
        logic                has_frame;
        logic                periodic;
        logic                failed;
        logic                ack;
        logic [FRAME_W-1:0]  frame;
    } t_cmd;

    localparam logic [CFG_IDX_W-1:0] CFG_FULL_THR  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_THR = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ERR_LIMIT = 4'd3;

    localparam logic [WEIGHT_W-1:0] FULL_THR_RST  = 16'd5000;
    localparam logic [WEIGHT_W-1:0] CLEAR_THR_RST = 16'd4000;
    localparam logic [CNT_W-1:0]    WINDOW_RST    = 4'd10;
    localparam logic [CNT_W-1:0]    ERR_LIMIT_RST = 4'd2;
    localparam logic [CNT_W-1:0]    CNT_MAX       = 4'd15;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 16'hFFFF;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

endpackage

### src/sfom_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfom_front - input stage
// Takes items from the input channel, decodes the kind and hands the
// decoded entry to the queue.
// ----------------------------------------------------------------------------
module sfom_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_in_kind,
    input  logic [sfom_pkg::FRAME_W-1:0]  i_in_frame,
    output logic                          o_push,
    output sfom_pkg::t_cmd                o_cmd,
    input  logic                          i_full
);

    logic           r_valid;
    sfom_pkg::t_cmd r_cmd;
    sfom_pkg::t_cmd n_cmd;
    logic           w_accept;

    assign o_push     = r_valid & ~i_full;
    assign o_in_stall = r_valid & i_full;
    assign w_accept   = i_in_valid & ~o_in_stall;
    assign o_cmd      = r_cmd;

    always_comb begin
        n_cmd.has_frame = 1'b0;
        n_cmd.periodic  = 1'b0;
        n_cmd.failed    = 1'b0;
        n_cmd.ack       = 1'b0;
        n_cmd.frame     = i_in_frame;
        unique case (sfom_pkg::t_kind'(i_in_kind))
            sfom_pkg::KIND_TOTAL: begin
                n_cmd.has_frame = 1'b1;
                n_cmd.periodic  = 1'b1;
            end
            sfom_pkg::KIND_FAIL: begin
                n_cmd.periodic  = 1'b1;
                n_cmd.failed    = 1'b1;
            end
            sfom_pkg::KIND_INCR: begin
                n_cmd.has_frame = 1'b1;
            end
            sfom_pkg::KIND_ACK: begin
                n_cmd.ack       = 1'b1;
            end
            default: begin
                n_cmd.ack       = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

### src/sfom_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfom_queue - short queue between front and back
// Register-based FIFO of decoded entries.
// ----------------------------------------------------------------------------
module sfom_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sfom_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output sfom_pkg::t_cmd o_cmd,
    output logic           o_empty
);

    localparam int Depth = sfom_pkg::QUEUE_DEPTH;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = $clog2(Depth + 1);

    sfom_pkg::t_cmd    r_mem [Depth];
    logic [PtrW-1:0]   r_wr_ptr;
    logic [PtrW-1:0]   r_rd_ptr;
    logic [CntW-1:0]   r_count;

    assign o_full  = (r_count == CntW'(Depth));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] ptr);
        ptr_inc = (ptr == PtrW'(Depth - 1)) ? '0 : ptr + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### src/sfom_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfom_back - frame parser and monitor state
// Scans one character per cycle, then updates the overload counter, the
// error window and the bin-full flag, and loads the output register.
// ----------------------------------------------------------------------------
module sfom_back #(
    parameter int FrameChars = sfom_pkg::FRAME_CHARS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [sfom_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sfom_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  sfom_pkg::t_cmd                    i_cmd,
    input  logic                              i_empty,
    output logic                              o_pop,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [sfom_pkg::WEIGHT_W-1:0]     o_out_weight,
    output logic                              o_out_weight_valid,
    output logic [1:0]                        o_out_over_level,
    output logic                              o_out_bin_alarm,
    output logic                              o_out_weigher_error
);

    localparam int CharCntW = (FrameChars > 1) ? $clog2(FrameChars) : 1;
    localparam int ProdW    = sfom_pkg::WEIGHT_W + 4;
    localparam int W        = sfom_pkg::WEIGHT_W;
    localparam int CW       = sfom_pkg::CNT_W;
    localparam int ChW      = sfom_pkg::CHAR_W;
    localparam int FW       = sfom_pkg::FRAME_W;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_PARSE  = 3'b010,
        ST_UPDATE = 3'b100
    } t_bstate;

    t_bstate r_state, n_state;

    // configuration
    logic [W-1:0]  r_full_thr;
    logic [W-1:0]  r_clear_thr;
    logic [CW-1:0] r_window;
    logic [CW-1:0] r_err_limit;

    // monitor state
    logic [1:0]    r_over;
    logic          r_ack;
    logic          r_full;
    logic          r_err;
    logic [CW-1:0] r_reads;
    logic [CW-1:0] r_fails;
    logic [1:0]    n_over;
    logic          n_ack;
    logic          n_full;
    logic          n_err;
    logic [CW-1:0] n_reads;
    logic [CW-1:0] n_fails;

    // item in work
    sfom_pkg::t_cmd        r_cmd;
    logic [FW-1:0]         r_shift;
    logic [W-1:0]          r_acc;
    logic                  r_neg;
    logic [CharCntW-1:0]   r_cnt;

    logic [ChW-1:0]   w_char;
    logic             w_digit;
    logic [ProdW-1:0] w_prod;
    logic [W-1:0]     n_acc;
    logic [W-1:0]     w_weight;
    logic             w_out_free;
    logic             w_done;
    logic             w_load;

    assign w_char  = r_shift[FW-1 -: ChW];
    assign w_digit = (w_char >= sfom_pkg::CH_ZERO) && (w_char <= sfom_pkg::CH_NINE);
    // acc * 10 + digit; ASCII digit value sits in the low nibble
    assign w_prod  = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1)
                   + {{(ProdW-4){1'b0}}, w_char[3:0]};
    assign n_acc   = (w_prod > {4'd0, sfom_pkg::WEIGHT_MAX}) ? sfom_pkg::WEIGHT_MAX
                                                             : w_prod[W-1:0];
    assign w_weight = r_neg ? '0 : r_acc;

    assign w_out_free = ~o_out_valid | ~i_out_stall;
    assign w_done     = (r_state == ST_UPDATE) && w_out_free;
    assign w_load     = ~i_empty && ((r_state == ST_IDLE) || w_done);
    assign o_pop      = w_load;

    // state update for the item held in r_cmd
    always_comb begin
        n_over  = r_over;
        n_ack   = r_ack;
        n_full  = r_full;
        n_err   = r_err;
        n_reads = r_reads;
        n_fails = r_fails;
        if (r_cmd.has_frame && r_cmd.periodic) begin
            if (w_weight >= r_full_thr) begin
                n_over = (r_over != 2'd0) ? 2'd3 : 2'd1;
            end else if (w_weight < r_clear_thr) begin
                if (r_over != 2'd0) begin
                    n_over = r_over - 2'd1;
                end
            end
        end
        if (r_cmd.periodic) begin
            if (r_reads != sfom_pkg::CNT_MAX) begin
                n_reads = r_reads + 1'b1;
            end
            if (r_cmd.failed && (r_fails != sfom_pkg::CNT_MAX)) begin
                n_fails = r_fails + 1'b1;
            end
            if (n_reads >= r_window) begin
                n_err   = (n_fails >= r_err_limit);
                n_reads = '0;
                n_fails = '0;
            end
            if (n_over == 2'd0) begin
                n_full = 1'b0;
                n_ack  = 1'b0;
            end else if (!r_ack && (n_over >= 2'd2)) begin
                n_full = 1'b1;
            end
        end
        if (r_cmd.ack) begin
            n_ack = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_load) begin
                    n_state = i_cmd.has_frame ? ST_PARSE : ST_UPDATE;
                end
            end
            ST_PARSE: begin
                if (r_cnt == CharCntW'(FrameChars - 1)) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (w_load) begin
                    n_state = i_cmd.has_frame ? ST_PARSE : ST_UPDATE;
                end else if (w_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_full_thr  <= sfom_pkg::FULL_THR_RST;
            r_clear_thr <= sfom_pkg::CLEAR_THR_RST;
            r_window    <= sfom_pkg::WINDOW_RST;
            r_err_limit <= sfom_pkg::ERR_LIMIT_RST;
            r_over      <= '0;
            r_ack       <= 1'b0;
            r_full      <= 1'b0;
            r_err       <= 1'b0;
            r_reads     <= '0;
            r_fails     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    sfom_pkg::CFG_FULL_THR:  r_full_thr  <= i_cfg_data;
                    sfom_pkg::CFG_CLEAR_THR: r_clear_thr <= i_cfg_data;
                    sfom_pkg::CFG_WINDOW:    r_window    <= i_cfg_data[CW-1:0];
                    sfom_pkg::CFG_ERR_LIMIT: r_err_limit <= i_cfg_data[CW-1:0];
                    default: begin
                    end
                endcase
            end
            if (w_done) begin
                r_over      <= n_over;
                r_ack       <= n_ack;
                r_full      <= n_full;
                r_err       <= n_err;
                r_reads     <= n_reads;
                r_fails     <= n_fails;
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cmd   <= i_cmd;
            r_shift <= i_cmd.frame;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_cnt   <= '0;
        end else if (r_state == ST_PARSE) begin
            r_shift <= r_shift << ChW;
            r_cnt   <= r_cnt + 1'b1;
            if (w_digit) begin
                r_acc <= n_acc;
            end else if (w_char == sfom_pkg::CH_MINUS) begin
                r_neg <= 1'b1;
            end
        end
        if (w_done) begin
            o_out_weight        <= r_cmd.has_frame ? w_weight : '0;
            o_out_weight_valid  <= r_cmd.has_frame;
            o_out_over_level    <= n_over;
            o_out_bin_alarm     <= n_full;
            o_out_weigher_error <= n_err;
        end
    end

endmodule

### src/scale_frame_overload_monitor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scale_frame_overload_monitor_top - weighing scale frame monitor
// Parses ASCII weight frames and tracks overload, bin-full and read errors.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one item per transfer:
//   a kind code and an eight-character frame, first character in the top
//   byte. Every item gives exactly one result on the output channel
//   (o_out_valid / i_out_stall), in order.
//   Configuration writes (i_cfg_valid / o_cfg_ready) go to the thresholds
//   and error window registers; o_cfg_ready is always high. Write them only
//   while no item is in flight. Unknown indexes are dropped.
//   The back end scans one character per cycle and loads the next item
//   as it finishes the last, so other kinds go through one per cycle
//   while the output is not stalled.
//   A front register and a two-entry queue decouple input from the back
//   end; a stalled result holds in the output register while the front
//   keeps taking items until the queue fills, then raises o_in_stall.
//   Reset (synchronous, active low) clears the queue, the monitor state
//   and loads the register defaults.
// ----------------------------------------------------------------------------
module scale_frame_overload_monitor_top #(
    parameter int FrameChars = sfom_pkg::FRAME_CHARS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_in_kind,
    input  logic [sfom_pkg::FRAME_W-1:0]      i_in_frame,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [sfom_pkg::WEIGHT_W-1:0]     o_out_weight,
    output logic                              o_out_weight_valid,
    output logic [1:0]                        o_out_over_level,
    output logic                              o_out_bin_alarm,
    output logic                              o_out_weigher_error,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sfom_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sfom_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    sfom_pkg::t_cmd w_front_cmd;
    sfom_pkg::t_cmd w_queue_cmd;
    logic           w_push;
    logic           w_full;
    logic           w_pop;
    logic           w_empty;

    assign o_cfg_ready = 1'b1;

    sfom_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_kind  (i_in_kind),
        .i_in_frame (i_in_frame),
        .o_push     (w_push),
        .o_cmd      (w_front_cmd),
        .i_full     (w_full)
    );

    sfom_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_cmd   (w_queue_cmd),
        .o_empty (w_empty)
    );

    sfom_back #(
        .FrameChars (FrameChars)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid & o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_cmd               (w_queue_cmd),
        .i_empty             (w_empty),
        .o_pop               (w_pop),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_out_weight        (o_out_weight),
        .o_out_weight_valid  (o_out_weight_valid),
        .o_out_over_level    (o_out_over_level),
        .o_out_bin_alarm     (o_out_bin_alarm),
        .o_out_weigher_error (o_out_weigher_error)
    );

endmodule
